// ===== hw/rtl/job_dispatch_scheduler_unit_assert.svh =====
// assertion macros shared by the scheduler checker
`ifndef JOB_DISPATCH_SCHEDULER_UNIT_ASSERT_SVH
`define JOB_DISPATCH_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define JDS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication, disabled while reset is asserted
`define JDS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// ===== hw/rtl/jds_pkg.sv =====
// shared types and constants of the job dispatch scheduler
`default_nettype none

package jds_pkg;

  // table geometry
  localparam int unsigned MAX_JOBS = 64;
  localparam int unsigned IDX_W    = $clog2(MAX_JOBS);
  localparam int unsigned CNT_W    = $clog2(MAX_JOBS + 1);

  // field widths
  localparam int unsigned ID_W   = 6;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned TIME_W = 32;

  // input action codes
  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_NEXT  = 2'd2
  } action_e;

  // result kind codes
  typedef enum logic [2:0] {
    KIND_ACK  = 3'd0,
    KIND_RAN  = 3'd1,
    KIND_IDLE = 3'd2,
    KIND_DONE = 3'd3,
    KIND_FULL = 3'd4
  } kind_e;

  // selection rule
  localparam logic MODE_FCFS = 1'b0;
  localparam logic MODE_SJF  = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // one job table entry with its finished flag
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] arrival;
    logic [TICK_W-1:0] burst;
    logic              fin;
  } job_entry_t;

  localparam int unsigned ENTRY_W = $bits(job_entry_t);

endpackage

`default_nettype wire

// ===== hw/rtl/jds_job_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
`default_nettype none

module jds_job_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, read data registered on a read enable
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/jds_ctrl.sv =====
// scheduler controller: table bookkeeping, ready-minimum scan and result words
`default_nettype none

module jds_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         mode_i,
  input  wire logic                         accept_i,
  input  wire logic [1:0]                   action_i,
  input  wire logic [jds_pkg::ID_W-1:0]     job_id_i,
  input  wire logic [jds_pkg::TICK_W-1:0]   arrival_i,
  input  wire logic [jds_pkg::TICK_W-1:0]   burst_i,
  output      logic                         busy_o,
  // job table ram
  output      logic                         ram_we_o,
  output      logic [jds_pkg::IDX_W-1:0]    ram_waddr_o,
  output      jds_pkg::job_entry_t          ram_wdata_o,
  output      logic                         ram_re_o,
  output      logic [jds_pkg::IDX_W-1:0]    ram_raddr_o,
  input  wire jds_pkg::job_entry_t          ram_rdata_i,
  // result word
  output      logic                         done_o,
  output      logic [2:0]                   kind_o,
  output      logic [jds_pkg::ID_W-1:0]     ran_id_o,
  output      logic [jds_pkg::TIME_W-1:0]   end_time_o,
  output      logic [jds_pkg::TIME_W-1:0]   waiting_time_o
);

  import jds_pkg::*;

  // control state
  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [TIME_W-1:0]    time_q, time_d;
  logic [CNT_W-1:0]     scan_q, scan_d;
  logic                 pvld_q, pvld_d;
  logic                 found_q, found_d;
  logic                 pending_q, pending_d;
  logic                 done_q, done_d;

  // payload state
  logic [IDX_W-1:0]     pidx_q, pidx_d;
  logic [IDX_W-1:0]     bidx_q, bidx_d;
  logic [TICK_W-1:0]    barr_q, barr_d;
  logic [TICK_W-1:0]    bburst_q, bburst_d;
  logic [ID_W-1:0]      bid_q, bid_d;
  logic [2:0]           kind_q, kind_d;
  logic [ID_W-1:0]      ran_id_q, ran_id_d;
  logic [TIME_W-1:0]    end_q, end_d;
  logic [TIME_W-1:0]    wait_q, wait_d;

  // compare stage signals
  logic                 ent_ready;
  logic                 ent_better;
  logic                 table_full;

  // candidate evaluation on the word read in the previous cycle
  always_comb begin
    ent_ready = !ram_rdata_i.fin &&
                ({{(TIME_W-TICK_W){1'b0}}, ram_rdata_i.arrival} <= time_q);
    if (mode_i == MODE_FCFS) begin
      ent_better = !found_q || (ram_rdata_i.arrival < barr_q);
    end else begin
      ent_better = !found_q || (ram_rdata_i.burst < bburst_q);
    end
  end

  assign table_full = (cnt_q == CNT_W'(MAX_JOBS));

  // control state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      time_q    <= '0;
      scan_q    <= '0;
      pvld_q    <= 1'b0;
      found_q   <= 1'b0;
      pending_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      time_q    <= time_d;
      scan_q    <= scan_d;
      pvld_q    <= pvld_d;
      found_q   <= found_d;
      pending_q <= pending_d;
      done_q    <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pidx_q   <= pidx_d;
    bidx_q   <= bidx_d;
    barr_q   <= barr_d;
    bburst_q <= bburst_d;
    bid_q    <= bid_d;
    kind_q   <= kind_d;
    ran_id_q <= ran_id_d;
    end_q    <= end_d;
    wait_q   <= wait_d;
  end

  // next state and outputs
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    time_d      = time_q;
    scan_d      = scan_q;
    pvld_d      = 1'b0;
    found_d     = found_q;
    pending_d   = pending_q;
    done_d      = 1'b0;
    pidx_d      = pidx_q;
    bidx_d      = bidx_q;
    barr_d      = barr_q;
    bburst_d    = bburst_q;
    bid_d       = bid_q;
    kind_d      = kind_q;
    ran_id_d    = ran_id_q;
    end_d       = end_q;
    wait_d      = wait_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = cnt_q[IDX_W-1:0];
    ram_wdata_o = '{id: job_id_i, arrival: arrival_i, burst: burst_i,
                    fin: (burst_i == '0)};
    ram_re_o    = 1'b0;
    ram_raddr_o = scan_q[IDX_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept_i) begin
          // default answer: plain acknowledge
          done_d   = 1'b1;
          kind_d   = KIND_ACK;
          ran_id_d = '0;
          end_d    = '0;
          wait_d   = '0;
          unique case (action_e'(action_i))
            ACT_CLEAR: begin
              cnt_d  = '0;
              time_d = '0;
            end
            ACT_LOAD: begin
              if (table_full) begin
                kind_d = KIND_FULL;
              end else begin
                // zero-burst jobs are stored already finished
                ram_we_o = 1'b1;
                cnt_d    = cnt_q + CNT_W'(1);
              end
            end
            ACT_NEXT: begin
              done_d    = 1'b0;
              scan_d    = '0;
              found_d   = 1'b0;
              pending_d = 1'b0;
              state_d   = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // issue stage: one table read per cycle
        if (scan_q < cnt_q) begin
          ram_re_o = 1'b1;
          pvld_d   = 1'b1;
          pidx_d   = scan_q[IDX_W-1:0];
          scan_d   = scan_q + CNT_W'(1);
        end else if (!pvld_q) begin
          state_d = ST_FINISH;
        end
        // compare stage: fold the returned entry into the running best
        if (pvld_q) begin
          if (!ram_rdata_i.fin) begin
            pending_d = 1'b1;
          end
          if (ent_ready && ent_better) begin
            found_d  = 1'b1;
            bidx_d   = pidx_q;
            barr_d   = ram_rdata_i.arrival;
            bburst_d = ram_rdata_i.burst;
            bid_d    = ram_rdata_i.id;
          end
        end
      end

      ST_FINISH: begin
        done_d   = 1'b1;
        ran_id_d = '0;
        wait_d   = '0;
        state_d  = ST_IDLE;
        if (found_q) begin
          kind_d      = KIND_RAN;
          ran_id_d    = bid_q;
          wait_d      = time_q - {{(TIME_W-TICK_W){1'b0}}, barr_q};
          time_d      = time_q + {{(TIME_W-TICK_W){1'b0}}, bburst_q};
          end_d       = time_d;
          // write the chosen entry back marked finished
          ram_we_o    = 1'b1;
          ram_waddr_o = bidx_q;
          ram_wdata_o = '{id: bid_q, arrival: barr_q, burst: bburst_q, fin: 1'b1};
        end else if (pending_q) begin
          kind_d = KIND_IDLE;
          time_d = time_q + TIME_W'(1);
          end_d  = time_d;
        end else begin
          kind_d = KIND_DONE;
          end_d  = time_q;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign kind_o         = kind_q;
  assign ran_id_o       = ran_id_q;
  assign end_time_o     = end_q;
  assign waiting_time_o = wait_q;

endmodule

`default_nettype wire

// ===== hw/rtl/job_dispatch_scheduler_unit.sv =====
// job dispatch scheduler top level: mode register, controller and job table
//
//   channel   handshake                 word
//   command   start, busy               action_i, job_id_i, arrival_i, burst_i
//   result    done_o (one-cycle strobe) kind_o, ran_id_o, end_time_o, waiting_time_o
//   config    cfg_valid_i, cfg_ready_o  cfg_wdata_i (selection mode)
//
// clear, load and reserved commands answer in the cycle after acceptance; busy stays low.
// a next command reads the job table once per loaded entry through the single ram
// read port, and answers only after the last entry has been compared.
// busy is high from acceptance until the result strobe; no command is taken then.
// reset empties the table, zeroes the time and sets shortest job first mode.
// results cannot be held off: each word is valid only in its strobe cycle.
`default_nettype none

module job_dispatch_scheduler_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic [1:0]                   action_i,
  input  wire logic [jds_pkg::ID_W-1:0]     job_id_i,
  input  wire logic [jds_pkg::TICK_W-1:0]   arrival_i,
  input  wire logic [jds_pkg::TICK_W-1:0]   burst_i,
  output      logic                         done_o,
  output      logic [2:0]                   kind_o,
  output      logic [jds_pkg::ID_W-1:0]     ran_id_o,
  output      logic [jds_pkg::TIME_W-1:0]   end_time_o,
  output      logic [jds_pkg::TIME_W-1:0]   waiting_time_o,
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic                         cfg_wdata_i
);

  import jds_pkg::*;

  logic             mode_q;
  logic             accept;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  job_entry_t       ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // mode register, writes always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SJF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // command acceptance
  assign accept = start && !busy;

  // controller
  jds_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_q),
    .accept_i       (accept),
    .action_i       (action_i),
    .job_id_i       (job_id_i),
    .arrival_i      (arrival_i),
    .burst_i        (burst_i),
    .busy_o         (busy),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (job_entry_t'(ram_rdata)),
    .done_o         (done_o),
    .kind_o         (kind_o),
    .ran_id_o       (ran_id_o),
    .end_time_o     (end_time_o),
    .waiting_time_o (waiting_time_o)
  );

  // job table
  jds_job_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_JOBS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ENTRY_W'(ram_wdata)),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/jds_checker.sv =====
// port-level checker for the job dispatch scheduler, bound to the top level
`default_nettype none
`include "job_dispatch_scheduler_unit_assert.svh"

module jds_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic [1:0]                   action_i,
  input wire logic                         done_o,
  input wire logic [2:0]                   kind_o,
  input wire logic [jds_pkg::ID_W-1:0]     ran_id_o,
  input wire logic [jds_pkg::TIME_W-1:0]   end_time_o,
  input wire logic [jds_pkg::TIME_W-1:0]   waiting_time_o
);

  import jds_pkg::*;

  // only a dispatched job carries an id or a waiting time
  `JDS_ASSERT_IMP(a_no_job_fields, clk_i, rst_ni, done_o && (kind_o != KIND_RAN), (ran_id_o == '0) && (waiting_time_o == '0))

  // acknowledge and table-full words report zero time
  `JDS_ASSERT_IMP(a_ack_zero_time, clk_i, rst_ni, done_o && ((kind_o == KIND_ACK) || (kind_o == KIND_FULL)), end_time_o == '0)

  // table commands answer in the very next cycle
  `JDS_ASSERT_NXT(a_table_cmd_answer, clk_i, rst_ni, start && !busy && (action_i != ACT_NEXT), done_o && !busy && ((kind_o == KIND_ACK) || (kind_o == KIND_FULL)))

  // a next command starts a scan and never answers with a table word
  `JDS_ASSERT_NXT(a_next_goes_busy, clk_i, rst_ni, start && !busy && (action_i == ACT_NEXT), busy && !done_o)

  // the result of a scan appears as busy drops
  `JDS_ASSERT_IMP(a_scan_answer, clk_i, rst_ni, $fell(busy), done_o && (kind_o != KIND_ACK) && (kind_o != KIND_FULL))

endmodule

bind job_dispatch_scheduler_unit jds_checker u_jds_checker (.*);

`default_nettype wire

// ===== sim/job_dispatch_scheduler_unit_test.sv =====
// self-checking testbench of the job dispatch scheduler with a schedule predictor
`timescale 1ns / 1ps

module job_dispatch_scheduler_unit_test;
  import jds_pkg::*;

  localparam logic [1:0] ACT_RESERVED = 2'd3;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned ITEM_GOAL   = 1500;
  localparam int unsigned DRAIN_TICKS = 80;

  // one schedule entry as seen on the result ports
  typedef struct packed {
    logic [2:0]        kind;
    logic [ID_W-1:0]   ran_id;
    logic [TIME_W-1:0] end_time;
    logic [TIME_W-1:0] waiting_time;
  } sched_entry_t;

  // predicted job table, time and the entries still owed by the block
  class schedule_board;
    logic              mode;
    logic [TICK_W-1:0] job_arrival[MAX_JOBS];
    logic [TICK_W-1:0] job_burst[MAX_JOBS];
    logic [ID_W-1:0]   job_tag[MAX_JOBS];
    bit                job_done[MAX_JOBS];
    int unsigned       job_count;
    logic [TIME_W-1:0] sched_time;
    sched_entry_t      owed_entries[$];
    kind_e             last_kind;
    int unsigned       mismatches;

    function new();
      mode = MODE_SJF;
      mismatches = 0;
      last_kind = KIND_ACK;
      wipe();
    endfunction

    function void wipe();
      foreach (job_done[i]) job_done[i] = 1'b0;
      job_count = 0;
      sched_time = '0;
    endfunction

    // work out the entry that one accepted command word causes
    function void note_command(logic [1:0] act, logic [ID_W-1:0] id,
                               logic [TICK_W-1:0] arr, logic [TICK_W-1:0] bur);
      sched_entry_t e;
      int best;
      bit found;
      bit left;
      e = '0;
      e.kind = KIND_ACK;
      case (act)
        ACT_CLEAR: wipe();
        ACT_LOAD: begin
          if (job_count >= MAX_JOBS) begin
            e.kind = KIND_FULL;
          end else begin
            job_tag[job_count] = id;
            job_arrival[job_count] = arr;
            job_burst[job_count] = bur;
            job_done[job_count] = (bur == '0);
            job_count++;
          end
        end
        ACT_NEXT: begin
          best = 0;
          found = 1'b0;
          left = 1'b0;
          // ready minimum, ties stay with the earlier-loaded job
          for (int i = 0; i < job_count; i++) begin
            if (!job_done[i]) begin
              left = 1'b1;
              if (TIME_W'(job_arrival[i]) <= sched_time) begin
                if (!found) begin
                  best = i;
                  found = 1'b1;
                end else if (mode == MODE_FCFS) begin
                  if (job_arrival[i] < job_arrival[best]) best = i;
                end else begin
                  if (job_burst[i] < job_burst[best]) best = i;
                end
              end
            end
          end
          if (!left) begin
            e.kind = KIND_DONE;
            e.end_time = sched_time;
          end else if (!found) begin
            sched_time = sched_time + 1;
            e.kind = KIND_IDLE;
            e.end_time = sched_time;
          end else begin
            e.kind = KIND_RAN;
            e.ran_id = job_tag[best];
            e.waiting_time = sched_time - TIME_W'(job_arrival[best]);
            sched_time = sched_time + TIME_W'(job_burst[best]);
            e.end_time = sched_time;
            job_done[best] = 1'b1;
          end
        end
        default: ;
      endcase
      last_kind = kind_e'(e.kind);
      owed_entries.push_back(e);
    endfunction

    // compare one strobed entry with the oldest one owed
    function void check_entry(sched_entry_t got);
      sched_entry_t exp;
      if (owed_entries.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: entry with none owed: kind %0d id %0d end %0d wait %0d",
                   $time, got.kind, got.ran_id, got.end_time, got.waiting_time);
        mismatches++;
        return;
      end
      exp = owed_entries.pop_front();
      if (got.kind !== exp.kind || got.ran_id !== exp.ran_id ||
          got.end_time !== exp.end_time || got.waiting_time !== exp.waiting_time) begin
        if (mismatches < 10)
          $display("%0t: mismatch exp kind %0d id %0d end %0d wait %0d, got %0d %0d %0d %0d",
                   $time, exp.kind, exp.ran_id, exp.end_time, exp.waiting_time,
                   got.kind, got.ran_id, got.end_time, got.waiting_time);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        action_i = ACT_CLEAR;
  logic [ID_W-1:0]   job_id_i = '0;
  logic [TICK_W-1:0] arrival_i = '0;
  logic [TICK_W-1:0] burst_i = '0;
  logic              done_o;
  logic [2:0]        kind_o;
  logic [ID_W-1:0]   ran_id_o;
  logic [TIME_W-1:0] end_time_o;
  logic [TIME_W-1:0] waiting_time_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_wdata_i = 1'b0;

  schedule_board board;
  int unsigned   words_sent = 0;
  int unsigned   quiet_cycles = 0;
  bit            steady = 1'b0;

  job_dispatch_scheduler_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .job_id_i       (job_id_i),
    .arrival_i      (arrival_i),
    .burst_i        (burst_i),
    .done_o         (done_o),
    .kind_o         (kind_o),
    .ran_id_o       (ran_id_o),
    .end_time_o     (end_time_o),
    .waiting_time_o (waiting_time_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1)
      board.check_entry({kind_o, ran_id_o, end_time_o, waiting_time_o});
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || done_o === 1'b1 ||
        (cfg_valid_i && cfg_ready_o === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // send one command word, with random gaps outside the steady stretch
  task automatic issue(input logic [1:0] act, input logic [ID_W-1:0] id,
                       input logic [TICK_W-1:0] arr, input logic [TICK_W-1:0] bur);
    if (!steady) begin
      while ($urandom_range(0, 99) < 25) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start <= 1'b1;
    action_i <= act;
    job_id_i <= id;
    arrival_i <= arr;
    burst_i <= bur;
    do @(posedge clk_i); while (busy !== 1'b0);
    board.note_command(act, id, arr, bur);
    words_sent++;
    steady = (words_sent >= 500 && words_sent < 800);
  endtask

  // command whose job fields are don't-care, filled with noise
  task automatic issue_bare(input logic [1:0] act);
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom;
    b = $urandom;
    issue(act, a[ID_W-1:0], a[31:16], b[15:0]);
  endtask

  // load a job, arrivals mostly near the start of time, bursts mostly short
  task automatic load_random(input int unsigned span);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [TICK_W-1:0] arr;
    logic [TICK_W-1:0] bur;
    a = $urandom;
    b = $urandom_range(0, 15);
    c = $urandom_range(0, span);
    arr = (b == 0) ? a[15:0] : c[15:0];
    a = $urandom;
    b = $urandom_range(0, 15);
    c = $urandom_range(1, 12);
    if (b == 0) bur = a[15:0];
    else if (b < 3) bur = '0;
    else bur = c[15:0];
    a = $urandom;
    issue(ACT_LOAD, a[ID_W-1:0], arr, bur);
  endtask

  // let every owed entry arrive before touching the mode register
  task automatic settle();
    start <= 1'b0;
    while (board.owed_entries.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= m;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    board.mode = m;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned jobs;
    int unsigned tries;
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // shortest job first after reset: empty table, reserved code, extremes, zero burst
    issue_bare(ACT_NEXT);
    issue(ACT_RESERVED, 6'h3f, 16'hffff, 16'hffff);
    issue(ACT_LOAD, 6'h3f, 16'h0000, 16'hffff);
    issue(ACT_LOAD, 6'h00, 16'h0000, 16'h0000);
    issue(ACT_LOAD, 6'h05, 16'hffff, 16'h0001);
    issue(ACT_LOAD, 6'h0a, 16'h0002, 16'h0003);
    repeat (4) issue_bare(ACT_NEXT);

    // first come first served with an idle tick and an arrival tie
    settle();
    write_mode(MODE_FCFS);
    issue_bare(ACT_CLEAR);
    issue(ACT_LOAD, 6'h01, 16'h0003, 16'h0009);
    issue(ACT_LOAD, 6'h02, 16'h0001, 16'h0004);
    issue(ACT_LOAD, 6'h03, 16'h0001, 16'h0002);
    repeat (5) issue_bare(ACT_NEXT);

    // burst tie under shortest job first
    settle();
    write_mode(MODE_SJF);
    issue_bare(ACT_CLEAR);
    issue(ACT_LOAD, 6'h07, 16'h0000, 16'h0005);
    issue(ACT_LOAD, 6'h08, 16'h0000, 16'h0005);
    repeat (3) issue_bare(ACT_NEXT);

    // random schedules, some filling the table, with stray commands mixed in
    while (words_sent < ITEM_GOAL) begin
      settle();
      if ($urandom_range(0, 2) == 0) write_mode($urandom_range(0, 1) != 0);
      if ($urandom_range(0, 9) != 0) issue_bare(ACT_CLEAR);
      jobs = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
      for (int j = 0; j < jobs; j++) begin
        load_random(4 * jobs);
        if ($urandom_range(0, 11) == 0) begin
          case ($urandom_range(0, 2))
            0: issue_bare(ACT_CLEAR);
            1: issue_bare(ACT_NEXT);
            default: issue_bare(ACT_RESERVED);
          endcase
        end
      end
      tries = 0;
      while (tries < jobs + 30 && board.last_kind != KIND_DONE) begin
        issue_bare(ACT_NEXT);
        if ($urandom_range(0, 14) == 0) load_random(4 * jobs);
        tries++;
      end
    end

    // drain
    start <= 1'b0;
    while (board.owed_entries.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TICKS) @(posedge clk_i);
    if (board.mismatches == 0 && board.owed_entries.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
